// File: rtl/mbrm_pkg.sv
// ----------------------------------------------------------------------------
// mbrm_pkg
// shared types and constants of the modbus tcp response matcher
// ----------------------------------------------------------------------------
`default_nettype none

package mbrm_pkg;

  // default ring depth and reset value of the slots-in-use register
  localparam int MAX_SLOTS_DEF = 128;
  localparam logic [7:0] ENTRIES_RESET = 8'd128;

  // input command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  // protocol constants
  localparam logic [15:0] PROTOCOL_MODBUS = 16'h0000;
  localparam logic [7:0]  FC_READ_MIN     = 8'h01;
  localparam logic [7:0]  FC_READ_MAX     = 8'h04;
  localparam logic [7:0]  FC_BIT_MAX      = 8'h02;
  localparam logic [16:0] LEN_OVERHEAD    = 17'd3;
  localparam logic [16:0] BIT_ROUND       = 17'd7;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NO_MATCH       = 3'd1,
    ST_BAD_PROTOCOL   = 3'd2,
    ST_NOT_READ       = 3'd3,
    ST_LENGTH_BAD     = 3'd4,
    ST_CODE_MISMATCH  = 3'd5,
    ST_COUNT_MISMATCH = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RECORD,
    S_SCAN,
    S_FINISH
  } fsm_state_t;

  // one stored request
  typedef struct packed {
    logic [15:0] tid;
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] qty;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic record;
    logic scan_start;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_hit;
    logic scan_miss;
    logic out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// File: rtl/modbus_tcp_response_matcher.sv
// ----------------------------------------------------------------------------
// modbus_tcp_response_matcher
// outstanding request table for modbus tcp reads with response header check
// ----------------------------------------------------------------------------
// sequence: a record beat passes through the record write and the result
//   hand-off; a check beat scans lim = min(slots in use, filled) slots at most
// throughput: one item at a time, taken only while idle; the table is
//   scanned one slot per cycle, ending at the first hit, through the
//   registered read port of the request ram
// reset: synchronous, clears the write pointer, the fill mark (all slots
//   invalid), the result register and sets the slot count to 128; no sweep
`default_nettype none

module modbus_tcp_response_matcher #(
  parameter int MAX_SLOTS = mbrm_pkg::MAX_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: slots in use
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  // request / response header beats
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic        command,
  input  wire logic [15:0] transaction_id,
  input  wire logic [15:0] protocol_id,
  input  wire logic [15:0] length_field,
  input  wire logic [7:0]  function_code,
  input  wire logic [7:0]  byte_count,
  input  wire logic [15:0] start_address,
  input  wire logic [15:0] quantity,
  // result beats
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             accepted,
  output logic [2:0]       status,
  output logic [6:0]       slot_index,
  output logic [7:0]       matched_function,
  output logic [15:0]      matched_address,
  output logic [15:0]      matched_quantity
);

  mbrm_pkg::ctl_cmd_t cmd;
  mbrm_pkg::ctl_sts_t sts;

  // sequencer: idle, record write, scan, result hand-off
  mbrm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .command   (command),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table, scan pointer, checks and the result register that holds a beat
  // while the consumer stalls
  mbrm_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .command          (command),
    .transaction_id   (transaction_id),
    .protocol_id      (protocol_id),
    .length_field     (length_field),
    .function_code    (function_code),
    .byte_count       (byte_count),
    .start_address    (start_address),
    .quantity         (quantity),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .accepted         (accepted),
    .status           (status),
    .slot_index       (slot_index),
    .matched_function (matched_function),
    .matched_address  (matched_address),
    .matched_quantity (matched_quantity)
  );

  // one item at a time: an accepted beat closes the input until its result is registered
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("input taken while an item is in progress");

  // an accepted result always carries the ok status
  a_accept_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && accepted) |-> (status == mbrm_pkg::ST_OK))
    else $error("accepted result with a failure status");

  // a missed lookup reports no slot contents
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status == mbrm_pkg::ST_NO_MATCH) |->
      (slot_index == 7'd0 && matched_function == 8'd0 &&
       matched_address == 16'd0 && matched_quantity == 16'd0 && !accepted))
    else $error("no-match result carries slot data");

endmodule

`default_nettype wire

// File: rtl/mbrm_ram.sv
// ----------------------------------------------------------------------------
// mbrm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mbrm_ram #(
  parameter int WIDTH  = 56,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/mbrm_ctrl.sv
// ----------------------------------------------------------------------------
// mbrm_ctrl
// sequencer: record, table scan and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module mbrm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               command,
  output logic                    req_stall,
  input  wire mbrm_pkg::ctl_sts_t sts,
  output mbrm_pkg::ctl_cmd_t      cmd
);

  mbrm_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbrm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      mbrm_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load = 1'b1;
          if (command == mbrm_pkg::CMD_RECORD) begin
            state_next = mbrm_pkg::S_RECORD;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = mbrm_pkg::S_SCAN;
          end
        end
      end
      mbrm_pkg::S_RECORD: begin
        cmd.record = 1'b1;
        state_next = mbrm_pkg::S_FINISH;
      end
      mbrm_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit || sts.scan_miss) begin
          state_next = mbrm_pkg::S_FINISH;
        end
      end
      mbrm_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        if (sts.out_free) begin
          state_next = mbrm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mbrm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mbrm_dp.sv
// ----------------------------------------------------------------------------
// mbrm_dp
// datapath: request table, scan pointer, header checks, result register
// ----------------------------------------------------------------------------
`default_nettype none

module mbrm_dp #(
  parameter int MAX_SLOTS = mbrm_pkg::MAX_SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mbrm_pkg::ctl_cmd_t cmd,
  output mbrm_pkg::ctl_sts_t      sts,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_wdata,
  input  wire logic               command,
  input  wire logic [15:0]        transaction_id,
  input  wire logic [15:0]        protocol_id,
  input  wire logic [15:0]        length_field,
  input  wire logic [7:0]         function_code,
  input  wire logic [7:0]         byte_count,
  input  wire logic [15:0]        start_address,
  input  wire logic [15:0]        quantity,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic                    accepted,
  output logic [2:0]              status,
  output logic [6:0]              slot_index,
  output logic [7:0]              matched_function,
  output logic [15:0]             matched_address,
  output logic [15:0]             matched_quantity
);

  localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CW    = (CNT_W > 8) ? CNT_W : 8;

  // control registers
  logic [7:0]       entries_in_use;
  logic [CNT_W-1:0] write_slot;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_valid;
  logic             match_found;

  // payload registers
  logic             item_cmd;
  logic [15:0]      item_tid;
  logic [15:0]      item_proto;
  logic [15:0]      item_len;
  logic [7:0]       item_fc;
  logic [7:0]       item_bc;
  logic [15:0]      item_addr;
  logic [15:0]      item_qty;
  logic [AW-1:0]    cmp_idx;
  logic [AW-1:0]    match_slot;
  logic [7:0]       match_fn;
  logic [15:0]      match_addr;
  logic [15:0]      match_qty;

  logic [CW-1:0]    cfg_ext;
  logic [CW-1:0]    n_w;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] lim;
  logic [AW-1:0]    rec_slot;
  logic [CNT_W-1:0] rec_next;
  logic             issue;
  logic             out_free;
  mbrm_pkg::entry_t wr_entry;
  mbrm_pkg::entry_t rd_entry;
  logic [16:0]      expect_bc;
  logic [15:0]      slot_w;
  logic             res_acc;
  mbrm_pkg::status_t res_status;
  logic             res_zero;

  // effective slots in use, clamped to 1..MAX_SLOTS
  always_comb begin
    cfg_ext = CW'(entries_in_use);
    if (entries_in_use == 8'd0) begin
      n_w = CW'(1);
    end else if (cfg_ext > CW'(MAX_SLOTS)) begin
      n_w = CW'(MAX_SLOTS);
    end else begin
      n_w = cfg_ext;
    end
    n   = n_w[CNT_W-1:0];
    // valid slots always form a prefix of the ring, so the fill mark bounds the scan
    lim = (fill < n) ? fill : n;
  end

  assign rec_slot = (write_slot >= n) ? '0 : write_slot[AW-1:0];
  assign rec_next = CNT_W'(rec_slot) + CNT_W'(1);
  assign issue    = cmd.scan && (rd_idx < lim);
  assign out_free = !res_valid || !res_stall;

  assign wr_entry = '{tid: item_tid, fn: item_fc, addr: item_addr, qty: item_qty};

  mbrm_ram #(
    .WIDTH  ($bits(mbrm_pkg::entry_t)),
    .DEPTH  (MAX_SLOTS),
    .ADDR_W (AW)
  ) u_table (
    .clk   (clk),
    .we    (cmd.record),
    .waddr (rec_slot),
    .wdata (wr_entry),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_entry)
  );

  assign sts.scan_hit  = cmp_valid && (rd_entry.tid == item_tid);
  assign sts.scan_miss = !cmp_valid && (rd_idx >= lim);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= mbrm_pkg::ENTRIES_RESET;
      write_slot     <= '0;
      fill           <= '0;
      rd_idx         <= '0;
      cmp_valid      <= 1'b0;
      match_found    <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_in_use <= cfg_wdata;
      end
      if (cmd.record) begin
        write_slot  <= rec_next;
        match_found <= 1'b1;
        if (rec_next > fill) begin
          fill <= rec_next;
        end
      end
      if (cmd.scan_start) begin
        rd_idx      <= '0;
        cmp_valid   <= 1'b0;
        match_found <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= issue;
        if (issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        if (sts.scan_hit) begin
          match_found <= 1'b1;
        end
      end
      if (cmd.finish && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd   <= command;
      item_tid   <= transaction_id;
      item_proto <= protocol_id;
      item_len   <= length_field;
      item_fc    <= function_code;
      item_bc    <= byte_count;
      item_addr  <= start_address;
      item_qty   <= quantity;
    end
    if (issue) begin
      cmp_idx <= rd_idx[AW-1:0];
    end
    if (cmd.record) begin
      match_slot <= rec_slot;
      match_fn   <= item_fc;
      match_addr <= item_addr;
      match_qty  <= item_qty;
    end else if (cmd.scan && sts.scan_hit) begin
      match_slot <= cmp_idx;
      match_fn   <= rd_entry.fn;
      match_addr <= rd_entry.addr;
      match_qty  <= rd_entry.qty;
    end
  end

  // response header checks, first failure wins
  always_comb begin
    if (item_fc <= mbrm_pkg::FC_BIT_MAX) begin
      expect_bc = ({1'b0, match_qty} + mbrm_pkg::BIT_ROUND) >> 3;
    end else begin
      expect_bc = {match_qty, 1'b0};
    end
    res_zero = 1'b0;
    res_acc  = 1'b0;
    if (item_cmd == mbrm_pkg::CMD_RECORD) begin
      res_acc    = 1'b1;
      res_status = mbrm_pkg::ST_OK;
    end else if (!match_found) begin
      res_zero   = 1'b1;
      res_status = mbrm_pkg::ST_NO_MATCH;
    end else if (item_proto != mbrm_pkg::PROTOCOL_MODBUS) begin
      res_status = mbrm_pkg::ST_BAD_PROTOCOL;
    end else if (item_fc < mbrm_pkg::FC_READ_MIN || item_fc > mbrm_pkg::FC_READ_MAX) begin
      res_status = mbrm_pkg::ST_NOT_READ;
    end else if ({1'b0, item_len} != (17'(item_bc) + mbrm_pkg::LEN_OVERHEAD)) begin
      res_status = mbrm_pkg::ST_LENGTH_BAD;
    end else if (item_fc != match_fn) begin
      res_status = mbrm_pkg::ST_CODE_MISMATCH;
    end else if (expect_bc != 17'(item_bc)) begin
      res_status = mbrm_pkg::ST_COUNT_MISMATCH;
    end else begin
      res_acc    = 1'b1;
      res_status = mbrm_pkg::ST_OK;
    end
    slot_w = 16'(match_slot);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && out_free) begin
      accepted         <= res_acc;
      status           <= res_status;
      slot_index       <= res_zero ? 7'd0 : slot_w[6:0];
      matched_function <= res_zero ? 8'd0 : match_fn;
      matched_address  <= res_zero ? 16'd0 : match_addr;
      matched_quantity <= res_zero ? 16'd0 : match_qty;
    end
  end

endmodule

`default_nettype wire

// File: tb/modbus_tcp_response_matcher_tb.sv
// ----------------------------------------------------------------------------
// modbus_tcp_response_matcher_tb
// self-checking bench for the modbus tcp request table and response check
// ----------------------------------------------------------------------------
// A short table of hand-picked beats covers the empty table, every status
// code, the byte count rules of bit and register reads, code 0 and 0xff,
// a repeated transaction id and the field extremes. It is followed by random
// phases, one per setting of the slots-in-use register (0, 1, 2, small,
// 128 and above), made mostly of recorded requests and well-formed
// responses to them, with broken headers and plain noise mixed in. A
// behavioral table copy predicts each result not typed by hand; results are
// compared field by field in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module modbus_tcp_response_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrm_pkg::*;

  localparam int MAX_SLOTS      = MAX_SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 1500;   // quiet cycles
  localparam int LATENCY_TAIL   = 140;    // cycles watched after the last result
  localparam int PHASES         = 8;
  localparam int DIRECTED_ROWS  = 25;

  // one request or response header beat
  typedef struct packed {
    logic        cmd;
    logic [15:0] tid;
    logic [15:0] proto;
    logic [15:0] len;
    logic [7:0]  fc;
    logic [7:0]  bc;
    logic [15:0] addr;
    logic [15:0] qty;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic        acc;
    status_t     st;
    logic [6:0]  slot;
    logic [7:0]  fn;
    logic [15:0] addr;
    logic [15:0] qty;
  } outcome_t;

  // directed row: the beat, and the result where it is obvious by eye
  typedef struct packed {
    beat_t    beat;
    logic     typed;
    outcome_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        command = CMD_RECORD;
  logic [15:0] transaction_id = 16'd0;
  logic [15:0] protocol_id = 16'd0;
  logic [15:0] length_field = 16'd0;
  logic [7:0]  function_code = 8'd0;
  logic [7:0]  byte_count = 8'd0;
  logic [15:0] start_address = 16'd0;
  logic [15:0] quantity = 16'd0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        accepted;
  logic [2:0]  status;
  logic [6:0]  slot_index;
  logic [7:0]  matched_function;
  logic [15:0] matched_address;
  logic [15:0] matched_quantity;

  modbus_tcp_response_matcher dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .command          (command),
    .transaction_id   (transaction_id),
    .protocol_id      (protocol_id),
    .length_field     (length_field),
    .function_code    (function_code),
    .byte_count       (byte_count),
    .start_address    (start_address),
    .quantity         (quantity),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .accepted         (accepted),
    .status           (status),
    .slot_index       (slot_index),
    .matched_function (matched_function),
    .matched_address  (matched_address),
    .matched_quantity (matched_quantity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the request table, owned by the stimulus process only
  // ---------------------------------------------------------------------------
  logic [7:0]  slots_cfg = ENTRIES_RESET;
  int unsigned write_ptr = 0;
  bit          tbl_valid [MAX_SLOTS];
  logic [15:0] tbl_tid   [MAX_SLOTS];
  logic [7:0]  tbl_fn    [MAX_SLOTS];
  logic [15:0] tbl_addr  [MAX_SLOTS];
  logic [15:0] tbl_qty   [MAX_SLOTS];

  outcome_t pending_outcomes [$];   // predicted results, oldest first
  int       mismatches = 0;
  int       quiet_cycles = 0;
  bit       tx_steady = 1'b0;       // sender runs back to back while set
  bit       rx_steady = 1'b0;       // receiver never stalls while set

  // register value 0 behaves as 1, anything past the ring depth as the depth
  function automatic int unsigned live_slots();
    int unsigned n;
    n = 32'(slots_cfg);
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    return n;
  endfunction

  // lowest live slot holding this transaction id, -1 when none
  function automatic int first_holder(logic [15:0] tid);
    int hit;
    hit = -1;
    for (int i = int'(live_slots()) - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_tid[i] == tid) hit = i;
    return hit;
  endfunction

  // data bytes a read response must carry: bits packed by 8 for coil and
  // discrete input reads, two bytes per register otherwise
  function automatic int unsigned read_bytes(logic [7:0] fc, logic [15:0] qty);
    if (fc <= FC_BIT_MAX) return (int'(qty) + 7) / 8;
    return int'(qty) * 2;
  endfunction

  // advance the table by one accepted beat and return the result it causes
  function automatic outcome_t resolve_beat(beat_t b);
    outcome_t o;
    int       s;
    o = '0;
    if (b.cmd == CMD_RECORD) begin
      // ring wraps to slot 0, also when the register was just lowered
      if (write_ptr >= live_slots()) write_ptr = 0;
      s = int'(write_ptr);
      tbl_valid[s] = 1'b1;
      tbl_tid[s]   = b.tid;
      tbl_fn[s]    = b.fc;
      tbl_addr[s]  = b.addr;
      tbl_qty[s]   = b.qty;
      write_ptr    = write_ptr + 1;
      o.acc  = 1'b1;
      o.st   = ST_OK;
      o.slot = 7'(s);
      o.fn   = b.fc;
      o.addr = b.addr;
      o.qty  = b.qty;
      return o;
    end
    s = first_holder(b.tid);
    if (s < 0) begin
      o.st = ST_NO_MATCH;
      return o;
    end
    o.slot = 7'(s);
    o.fn   = tbl_fn[s];
    o.addr = tbl_addr[s];
    o.qty  = tbl_qty[s];
    // header checks in priority order, first failure wins
    if (b.proto != PROTOCOL_MODBUS) o.st = ST_BAD_PROTOCOL;
    else if (b.fc < FC_READ_MIN || b.fc > FC_READ_MAX) o.st = ST_NOT_READ;
    else if (int'(b.len) != int'(b.bc) + 3) o.st = ST_LENGTH_BAD;
    else if (b.fc != tbl_fn[s]) o.st = ST_CODE_MISMATCH;
    else if (read_bytes(tbl_fn[s], tbl_qty[s]) != int'(b.bc)) o.st = ST_COUNT_MISMATCH;
    else begin
      o.acc = 1'b1;
      o.st  = ST_OK;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // directed beats, filled from slot 0 upward at the reset slot count
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty table, nothing can match
    '{'{CMD_CHECK,  16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_NO_MATCH, 7'd0, 8'h00, 16'h0000, 16'h0000}},
    // register read of 125 words into slot 0, top address
    '{'{CMD_RECORD, 16'h1234, 16'hffff, 16'hffff, 8'h03, 8'hff, 16'hffff, 16'h007d},
      1'b1, '{1'b1, ST_OK, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'hffff, 16'h0000, 8'h03, 8'h00, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_BAD_PROTOCOL, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    // function code 0, 0xff and the first code past the reads
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h00fd, 8'h00, 8'hfa, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_NOT_READ, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h00fd, 8'hff, 8'hfa, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_NOT_READ, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h00fd, 8'h05, 8'hfa, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_NOT_READ, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'hffff, 8'h03, 8'hfa, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_LENGTH_BAD, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h00fd, 8'h04, 8'hfa, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_CODE_MISMATCH, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h0003, 8'h03, 8'h00, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_COUNT_MISMATCH, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h00fd, 8'h03, 8'hfa, 16'h0000, 16'h0000},
      1'b1, '{1'b1, ST_OK, 7'd0, 8'h03, 16'hffff, 16'h007d}},
    // 19 coils round up to 3 bytes
    '{'{CMD_RECORD, 16'hffff, 16'h0000, 16'h0000, 8'h01, 8'h00, 16'h0000, 16'h0013},
      1'b1, '{1'b1, ST_OK, 7'd1, 8'h01, 16'h0000, 16'h0013}},
    '{'{CMD_CHECK,  16'hffff, 16'h0000, 16'h0006, 8'h01, 8'h03, 16'hffff, 16'hffff},
      1'b1, '{1'b1, ST_OK, 7'd1, 8'h01, 16'h0000, 16'h0013}},
    // zero inputs, zero bytes
    '{'{CMD_RECORD, 16'h0000, 16'h0000, 16'h0000, 8'h02, 8'h00, 16'h8000, 16'h0000},
      1'b1, '{1'b1, ST_OK, 7'd2, 8'h02, 16'h8000, 16'h0000}},
    '{'{CMD_CHECK,  16'h0000, 16'h0000, 16'h0003, 8'h02, 8'h00, 16'h0000, 16'h0000},
      1'b1, '{1'b1, ST_OK, 7'd2, 8'h02, 16'h8000, 16'h0000}},
    // full quantity can never fit a byte count
    '{'{CMD_RECORD, 16'habcd, 16'h0000, 16'h0000, 8'h04, 8'h00, 16'h7fff, 16'hffff},
      1'b1, '{1'b1, ST_OK, 7'd3, 8'h04, 16'h7fff, 16'hffff}},
    '{'{CMD_CHECK,  16'habcd, 16'h0000, 16'h0101, 8'h04, 8'hfe, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_COUNT_MISMATCH, 7'd3, 8'h04, 16'h7fff, 16'hffff}},
    '{'{CMD_RECORD, 16'h5555, 16'h0000, 16'h0000, 8'h01, 8'h00, 16'h0001, 16'hffff},
      1'b1, '{1'b1, ST_OK, 7'd4, 8'h01, 16'h0001, 16'hffff}},
    '{'{CMD_CHECK,  16'h5555, 16'h0000, 16'h0102, 8'h01, 8'hff, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_COUNT_MISMATCH, 7'd4, 8'h01, 16'h0001, 16'hffff}},
    // repeated transaction id: the lower slot keeps answering
    '{'{CMD_RECORD, 16'h1234, 16'h0000, 16'h0000, 8'h01, 8'h00, 16'h0101, 16'h0008},
      1'b0, '0},
    '{'{CMD_CHECK,  16'h1234, 16'h0000, 16'h00fd, 8'h03, 8'hfa, 16'h0000, 16'h0000},
      1'b0, '0},
    // non-read codes are stored as given
    '{'{CMD_RECORD, 16'h00ff, 16'h0000, 16'h0000, 8'h00, 8'h00, 16'haaaa, 16'h5555},
      1'b1, '{1'b1, ST_OK, 7'd6, 8'h00, 16'haaaa, 16'h5555}},
    '{'{CMD_CHECK,  16'h00ff, 16'h0000, 16'h0004, 8'h01, 8'h01, 16'h0000, 16'h0000},
      1'b0, '0},
    '{'{CMD_RECORD, 16'h2222, 16'h0000, 16'h0000, 8'hff, 8'h00, 16'h0000, 16'h0000},
      1'b1, '{1'b1, ST_OK, 7'd7, 8'hff, 16'h0000, 16'h0000}},
    '{'{CMD_CHECK,  16'h2222, 16'h0000, 16'h0003, 8'h02, 8'h00, 16'h0000, 16'h0000},
      1'b0, '0},
    // no match outranks a bad protocol id
    '{'{CMD_CHECK,  16'h1235, 16'h0001, 16'h0003, 8'h02, 8'h00, 16'h0000, 16'h0000},
      1'b1, '{1'b0, ST_NO_MATCH, 7'd0, 8'h00, 16'h0000, 16'h0000}}
  };

  // slot counts of the random phases, with the beats spent in each
  logic [7:0] phase_slots [PHASES] = '{8'd4, 8'd0, 8'd255, 8'd1, 8'd2, 8'd37, 8'd200, 8'd128};
  int         phase_beats [PHASES] = '{70, 50, 200, 40, 50, 120, 120, 100};

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // transaction id of some valid slot below span, else the fallback
  function automatic logic [15:0] pick_stored_tid(int unsigned span, logic [15:0] fallback);
    int j;
    for (int tries = 0; tries < 8; tries++) begin
      j = $urandom_range(0, span - 1);
      if (tbl_valid[j]) return tbl_tid[j];
    end
    return fallback;
  endfunction

  task automatic make_random_beat(output beat_t b);
    int          s;
    int unsigned roll;
    b.cmd   = ($urandom_range(0, 9) < 4) ? CMD_RECORD : CMD_CHECK;
    b.tid   = 16'($urandom);
    b.proto = 16'($urandom);
    b.len   = 16'($urandom);
    b.fc    = 8'($urandom);
    b.bc    = 8'($urandom);
    b.addr  = 16'($urandom);
    b.qty   = 16'($urandom);
    if (b.cmd == CMD_RECORD) begin
      // mostly fresh ids, some repeats; mostly reads whose answer fits a byte
      if ($urandom_range(0, 9) < 3) b.tid = pick_stored_tid(MAX_SLOTS, b.tid);
      if ($urandom_range(0, 9) != 0) b.fc = 8'($urandom_range(1, 4));
      if ($urandom_range(0, 9) != 0)
        b.qty = (b.fc <= FC_BIT_MAX) ? 16'($urandom_range(0, 2040)) : 16'($urandom_range(0, 127));
      return;
    end
    roll = $urandom_range(0, 9);
    if (roll < 6) b.tid = pick_stored_tid(live_slots(), b.tid);
    else if (roll < 8) b.tid = pick_stored_tid(MAX_SLOTS, b.tid);   // may hit a stale slot
    s = first_holder(b.tid);
    if (s >= 0 && $urandom_range(0, 3) != 0) begin
      // well-formed answer to the stored request
      b.proto = PROTOCOL_MODBUS;
      b.fc    = tbl_fn[s];
      b.bc    = 8'(read_bytes(tbl_fn[s], tbl_qty[s]));
      b.len   = 16'(int'(b.bc) + 3);
      // then break one thing in a third of them
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: b.proto = 16'($urandom_range(1, 65535));
          1: b.fc    = 8'($urandom_range(0, 7));
          2: b.len   = b.len ^ (16'd1 << $urandom_range(0, 15));
          default: begin
            b.bc  = b.bc + 8'($urandom_range(1, 255));
            b.len = 16'(int'(b.bc) + 3);
          end
        endcase
      end
    end else begin
      // noise, with enough plausible fields to get past the early checks
      if ($urandom_range(0, 1) == 0) b.proto = PROTOCOL_MODBUS;
      if ($urandom_range(0, 1) == 0) b.fc = 8'($urandom_range(0, 7));
      if ($urandom_range(0, 1) == 0) b.len = 16'(int'(b.bc) + 3);
    end
  endtask

  // present one beat after a random gap, hold it until taken, then predict
  task automatic send_beat(beat_t b, logic typed, outcome_t typed_want);
    int unsigned gap;
    outcome_t    o;
    if ($urandom_range(0, 29) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid      <= 1'b1;
    command        <= b.cmd;
    transaction_id <= b.tid;
    protocol_id    <= b.proto;
    length_field   <= b.len;
    function_code  <= b.fc;
    byte_count     <= b.bc;
    start_address  <= b.addr;
    quantity       <= b.qty;
    do @(posedge clk); while (req_stall);
    o = resolve_beat(b);
    pending_outcomes.push_back(typed ? typed_want : o);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    beat_t b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      // the register is only touched with the table idle
      wait_drained();
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_slots[p];
      @(posedge clk);
      cfg_we    <= 1'b0;
      slots_cfg = phase_slots[p];
      for (int k = 0; k < phase_beats[p]; k++) begin
        make_random_beat(b);
        send_beat(b, 1'b0, '0);
      end
    end

    wait_drained();
    // watch a little longer for stray result beats
    repeat (LATENCY_TAIL) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stall per beat, with stretches of none
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    forever begin
      if ($urandom_range(0, 29) == 0) rx_steady = !rx_steady;
      hold = rx_steady ? 0 : $urandom_range(0, 6);
      if (hold != 0) begin
        res_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare each taken result beat with the oldest prediction; watchdog
  outcome_t oldest;
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (pending_outcomes.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          oldest = pending_outcomes.pop_front();
          check_field("accepted", 16'(oldest.acc), 16'(accepted));
          check_field("status", 16'(oldest.st), 16'(status));
          check_field("slot_index", 16'(oldest.slot), 16'(slot_index));
          check_field("matched_function", 16'(oldest.fn), 16'(matched_function));
          check_field("matched_address", oldest.addr, matched_address);
          check_field("matched_quantity", oldest.qty, matched_quantity);
        end
      end
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
